// File: hw/rtl/i2p_pkg.sv
// Package: types, character codes and helpers for the infix-to-postfix converter.
package i2p_pkg;

  // Default operator stack depth
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_DIG_LO = 8'h30;  // '0'
  localparam logic [7:0] CH_DIG_HI = 8'h39;  // '9'
  localparam logic [7:0] CH_UC_LO  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UC_HI  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LC_LO  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LC_HI  = 8'h7A;  // 'z'

  // Operator priorities
  localparam logic [1:0] RANK_PAREN = 2'd0;
  localparam logic [1:0] RANK_ADD   = 2'd1;
  localparam logic [1:0] RANK_MUL   = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_OTHER
  } cls_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CLOSE,
    S_OPER,
    S_FLUSH,
    S_FETCH,
    S_DRAIN,
    S_LOAD,
    S_WAIT
  } state_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       no_char;
    err_e       error_code;
    logic       last_of_run;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    cls_e       cls;
    logic       end_of_expr;
  } q_item_t;

  function automatic logic [1:0] char_rank(input logic [7:0] c);
    logic [1:0] r;
    r = RANK_PAREN;
    if (c == CH_PLUS || c == CH_MINUS) begin
      r = RANK_ADD;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      r = RANK_MUL;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/i2p_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2p_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds when not reading
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/i2p_front.sv
// Front end: accepts characters, classifies them and queues them for the back end.
module i2p_front
  import i2p_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  input  logic     q_pop_i,
  output q_item_t  q_item_o
);

  localparam int unsigned QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t           fifo_q [QUEUE_DEPTH];
  logic [QA_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QA_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]   cnt_q, cnt_d;
  q_item_t           cls_item;
  logic              full, empty, push, pop;

  // Classify the incoming character
  always_comb begin
    cls_item.ch          = in_item_i.in_char;
    cls_item.end_of_expr = in_item_i.end_of_expr;
    if ((in_item_i.in_char >= CH_DIG_LO && in_item_i.in_char <= CH_DIG_HI) ||
        (in_item_i.in_char >= CH_UC_LO && in_item_i.in_char <= CH_UC_HI) ||
        (in_item_i.in_char >= CH_LC_LO && in_item_i.in_char <= CH_LC_HI)) begin
      cls_item.cls = CLS_ALNUM;
    end else if (in_item_i.in_char == CH_LPAREN) begin
      cls_item.cls = CLS_OPEN;
    end else if (in_item_i.in_char == CH_RPAREN) begin
      cls_item.cls = CLS_CLOSE;
    end else if (char_rank(in_item_i.in_char) != RANK_PAREN) begin
      cls_item.cls = CLS_OPER;
    end else begin
      cls_item.cls = CLS_OTHER;
    end
  end

  // Queue control
  assign full       = (cnt_q == QC_W'(QUEUE_DEPTH));
  assign empty      = (cnt_q == '0);
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign pop        = q_pop_i && !empty;
  assign q_valid_o  = !empty;
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QA_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QA_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

// File: hw/rtl/i2p_exec.sv
// Back end: operator stack sequencer, run buffer and result output register.
module i2p_exec
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_pop_o,
  input  q_item_t   q_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIDX_W    = $clog2(STACK_DEPTH);
  localparam int unsigned RUN_DEPTH = STACK_DEPTH + 1;
  localparam int unsigned LEN_W     = $clog2(RUN_DEPTH + 1);
  localparam int unsigned RIDX_W    = $clog2(RUN_DEPTH);

  state_e            state_q, state_d;
  state_e            ret_q, ret_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  err_e              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  q_item_t           cur_q, cur_d;
  logic [7:0]        top_q, top_d;
  out_item_t         out_q, out_d;

  // Stack and run buffer ports
  logic              stk_we, stk_re;
  logic [SIDX_W-1:0] stk_waddr, stk_raddr;
  logic [7:0]        stk_rdata;
  logic              rb_we, rb_re;
  logic [RIDX_W-1:0] rb_waddr, rb_raddr;
  logic [7:0]        rb_wdata, rb_rdata;

  // Status terms
  logic              stk_empty, stk_full, fetch_needed, top_is_open, pop_oper;
  logic              out_acc;
  logic [CNT_W-1:0]  cnt_m2;
  logic [LEN_W-1:0]  idx_nx;
  state_e            after_char, close_ret;

  // Per-cycle actions
  logic              emit_en, pop_en, push_en, err_set;
  logic [7:0]        emit_ch;
  err_e              err_val;

  assign stk_empty    = (count_q == '0);
  assign stk_full     = (count_q == CNT_W'(STACK_DEPTH));
  assign fetch_needed = (count_q > CNT_W'(1));
  assign top_is_open  = (top_q == CH_LPAREN);
  assign pop_oper     = !stk_empty && (char_rank(top_q) >= char_rank(cur_q.ch));
  assign out_acc      = out_valid_q && !out_stall_i;
  assign cnt_m2       = count_q - CNT_W'(2);
  assign idx_nx       = idx_q + LEN_W'(1);
  assign after_char   = cur_q.end_of_expr ? S_FLUSH : S_DRAIN;
  assign close_ret    = top_is_open ? after_char : S_CLOSE;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (cur_q.cls)
          CLS_CLOSE: state_d = S_CLOSE;
          CLS_OPER:  state_d = S_OPER;
          default:   state_d = after_char;
        endcase
      end
      S_CLOSE: begin
        if (stk_empty) begin
          state_d = after_char;
        end else begin
          state_d = fetch_needed ? S_FETCH : close_ret;
        end
      end
      S_OPER: begin
        if (pop_oper) begin
          state_d = fetch_needed ? S_FETCH : S_OPER;
        end else begin
          state_d = after_char;
        end
      end
      S_FLUSH: begin
        if (stk_empty) begin
          state_d = S_DRAIN;
        end else begin
          state_d = fetch_needed ? S_FETCH : S_FLUSH;
        end
      end
      S_FETCH: state_d = ret_q;
      S_DRAIN: state_d = (len_q == '0) ? S_WAIT : S_LOAD;
      S_LOAD:  state_d = S_WAIT;
      S_WAIT: begin
        if (out_acc) state_d = out_q.last_of_run ? S_IDLE : S_LOAD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    ret_d       = ret_q;
    count_d     = count_q;
    len_d       = len_q;
    idx_d       = idx_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    cur_d       = cur_q;
    top_d       = top_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    emit_en     = 1'b0;
    emit_ch     = top_q;
    pop_en      = 1'b0;
    push_en     = 1'b0;
    err_set     = 1'b0;
    err_val     = ERR_NONE;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = count_q[SIDX_W-1:0];
    stk_raddr   = cnt_m2[SIDX_W-1:0];
    rb_we       = 1'b0;
    rb_waddr    = len_q[RIDX_W-1:0];
    rb_wdata    = emit_ch;
    rb_re       = 1'b0;
    rb_raddr    = idx_q[RIDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          len_d   = '0;
          err_d   = ERR_NONE;
        end
      end
      S_DISPATCH: begin
        unique case (cur_q.cls)
          CLS_ALNUM: begin
            emit_en = 1'b1;
            emit_ch = cur_q.ch;
          end
          CLS_OPEN: push_en = 1'b1;
          default: ;
        endcase
      end
      S_CLOSE: begin
        ret_d = close_ret;
        if (stk_empty) begin
          err_set = 1'b1;
          err_val = ERR_UNMATCHED;
        end else begin
          pop_en  = 1'b1;
          emit_en = !top_is_open;
        end
      end
      S_OPER: begin
        ret_d = S_OPER;
        if (pop_oper) begin
          pop_en  = 1'b1;
          emit_en = 1'b1;
        end else begin
          push_en = 1'b1;
        end
      end
      S_FLUSH: begin
        ret_d = S_FLUSH;
        if (!stk_empty) begin
          pop_en = 1'b1;
          if (top_is_open) begin
            err_set = 1'b1;
            err_val = ERR_UNMATCHED;
          end else begin
            emit_en = 1'b1;
          end
        end
      end
      S_FETCH: top_d = stk_rdata;
      S_DRAIN: begin
        idx_d = '0;
        if (len_q == '0) begin
          out_d.out_char    = 8'h00;
          out_d.no_char     = 1'b1;
          out_d.error_code  = err_q;
          out_d.last_of_run = 1'b1;
          out_valid_d       = 1'b1;
        end else begin
          rb_re    = 1'b1;
          rb_raddr = '0;
        end
      end
      S_LOAD: begin
        out_d.out_char    = rb_rdata;
        out_d.no_char     = 1'b0;
        out_d.error_code  = err_q;
        out_d.last_of_run = (idx_nx == len_q);
        out_valid_d       = 1'b1;
      end
      S_WAIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (!out_q.last_of_run) begin
            idx_d    = idx_nx;
            rb_re    = 1'b1;
            rb_raddr = idx_nx[RIDX_W-1:0];
          end
        end
      end
      default: ;
    endcase

    // Emit into the run buffer
    if (emit_en && (len_q < LEN_W'(RUN_DEPTH))) begin
      rb_we    = 1'b1;
      rb_wdata = emit_ch;
      len_d    = len_q + LEN_W'(1);
    end

    // Pop; fetch the new top when entries remain below it
    if (pop_en) begin
      count_d = count_q - CNT_W'(1);
      stk_re  = fetch_needed;
    end

    // Push the current character, or flag overflow
    if (push_en) begin
      if (stk_full) begin
        err_set = 1'b1;
        err_val = ERR_OVERFLOW;
      end else begin
        stk_we  = 1'b1;
        top_d   = cur_q.ch;
        count_d = count_q + CNT_W'(1);
      end
    end

    // First error of the run sticks
    if (err_set && (err_q == ERR_NONE)) begin
      err_d = err_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      count_q     <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      count_q     <= count_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    top_q <= top_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Operator stack
  i2p_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (cur_q.ch),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Run buffer: holds a run's characters until its error code is known
  i2p_ram #(
    .WIDTH (8),
    .DEPTH (RUN_DEPTH)
  ) u_runbuf (
    .clk_i   (clk_i),
    .we_i    (rb_we),
    .waddr_i (rb_waddr),
    .wdata_i (rb_wdata),
    .re_i    (rb_re),
    .raddr_i (rb_raddr),
    .rdata_o (rb_rdata)
  );

endmodule

// File: hw/rtl/infix_to_postfix_converter_unit.sv
// Flow: each item is queued, popped and dispatched; each stack pop may add a fetch of the new
//   top; the run then drains and each result is loaded and held until taken. Items are
//   handled one at a time by the single back-end sequencer, slowed by the registered
//   read of the stack RAM; the front queues up to two items meanwhile.
// Reset (rst_ni, async, active low) clears the queue, stack count and sequencer at once;
//   stack and run buffer contents are not cleared and need no clearing pass.
module infix_to_postfix_converter_unit
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic    q_valid, q_pop;
  q_item_t q_item;

  // Accept and classify
  i2p_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  // Carry out stack operations and deliver results
  i2p_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/i2p_postfix_checker.sv
`timescale 1ns / 1ps
// Checker for the infix-to-postfix converter: predicts each run of postfix items and compares.
module i2p_postfix_checker
  import i2p_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        mismatch_cnt_o,
  output int        pending_o
);

  localparam int MAX_RUN    = STACK_DEPTH_DEF + 1;
  localparam int REPORT_MAX = 10;

  // Shadow operator stack and the postfix items still owed by the block
  logic [7:0] op_stack [STACK_DEPTH_DEF];
  int         op_depth     = 0;
  out_item_t  postfix_q[$];
  int         mismatch_cnt = 0;
  int         pending      = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_o      = pending;

  function automatic logic [1:0] op_priority(input logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS: return RANK_ADD;
      CH_STAR, CH_SLASH: return RANK_MUL;
      default:           return RANK_PAREN;
    endcase
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= CH_DIG_LO && c <= CH_DIG_HI) || (c >= CH_UC_LO && c <= CH_UC_HI) ||
           (c >= CH_LC_LO && c <= CH_LC_HI);
  endfunction

  // Push onto the shadow stack; a full stack drops the character and flags overflow
  function automatic void push_operator(input logic [7:0] c, inout err_e err);
    if (op_depth >= STACK_DEPTH_DEF) begin
      if (err == ERR_NONE) err = ERR_OVERFLOW;
    end else begin
      op_stack[op_depth] = c;
      op_depth++;
    end
  endfunction

  // Work out the run of postfix items that one input item causes
  function automatic void convert_char(input in_item_t it);
    logic [7:0] run_chars [MAX_RUN];
    int         run_len;
    err_e       err;
    logic [7:0] c;
    logic [7:0] t;
    logic       found;
    out_item_t  res;
    run_len = 0;
    err     = ERR_NONE;
    found   = 1'b0;
    c       = it.in_char;
    if (is_operand(c)) begin
      run_chars[run_len] = c;
      run_len++;
    end else if (c == CH_LPAREN) begin
      push_operator(c, err);
    end else if (c == CH_RPAREN) begin
      // pop down to the matching open parenthesis
      while (op_depth > 0 && !found) begin
        op_depth--;
        t = op_stack[op_depth];
        if (t == CH_LPAREN) begin
          found = 1'b1;
        end else if (run_len < MAX_RUN) begin
          run_chars[run_len] = t;
          run_len++;
        end
      end
      if (!found && err == ERR_NONE) err = ERR_UNMATCHED;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      // pop operators of equal or higher priority, then push
      while (op_depth > 0 && op_priority(op_stack[op_depth - 1]) >= op_priority(c)) begin
        op_depth--;
        if (run_len < MAX_RUN) begin
          run_chars[run_len] = op_stack[op_depth];
          run_len++;
        end
      end
      push_operator(c, err);
    end
    // end of expression: flush everything, dropping stray open parentheses
    if (it.end_of_expr) begin
      while (op_depth > 0) begin
        op_depth--;
        t = op_stack[op_depth];
        if (t == CH_LPAREN) begin
          if (err == ERR_NONE) err = ERR_UNMATCHED;
        end else if (run_len < MAX_RUN) begin
          run_chars[run_len] = t;
          run_len++;
        end
      end
    end
    if (run_len == 0) begin
      res.out_char    = 8'h00;
      res.no_char     = 1'b1;
      res.error_code  = err;
      res.last_of_run = 1'b1;
      postfix_q.push_back(res);
    end else begin
      for (int k = 0; k < run_len; k++) begin
        res.out_char    = run_chars[k];
        res.no_char     = 1'b0;
        res.error_code  = err;
        res.last_of_run = (k == run_len - 1);
        postfix_q.push_back(res);
      end
    end
  endfunction

  // Compare one output item with the oldest expected one
  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (postfix_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $display("unexpected item: char %h no_char %b err %0d last %b",
                 got.out_char, got.no_char, got.error_code, got.last_of_run);
    end else begin
      want = postfix_q.pop_front();
      if (got.out_char !== want.out_char || got.no_char !== want.no_char ||
          got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("item mismatch: expected char %h no_char %b err %0d last %b, %s",
                   want.out_char, want.no_char, want.error_code, want.last_of_run,
                   $sformatf("got char %h no_char %b err %0d last %b",
                             got.out_char, got.no_char, got.error_code, got.last_of_run));
      end
    end
  endfunction

  // Watch both channels; input first, a result never leaves on the edge its item enters
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_depth = 0;
      postfix_q.delete();
      pending = 0;
    end else begin
      if (in_valid_i && !in_stall_i) convert_char(in_item_i);
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      pending = postfix_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the infix-to-postfix converter: clock, reset, stimulus and verdict.
module testbench;
  import i2p_pkg::*;

  localparam int         ITEM_TARGET    = 210;
  localparam int         CALM_FROM      = 180;  // no idling from here on
  localparam int         PRESSURE_AT    = 100;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         DRAIN_CYCLES   = 64;
  localparam logic [7:0] CH_SPACE       = 8'h20;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int         mismatch_cnt;
  int         pending;
  int         item_cnt     = 0;
  int         quiet_cycles = 0;
  bit         gaps_on      = 1'b1;
  bit         sender_gaps  = 1'b1;
  bit         hold_pending = 1'b0;
  logic [7:0] expr_q[$];

  always #1 clk_i = ~clk_i;

  infix_to_postfix_converter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  i2p_postfix_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_item_i     (out_item),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  // Watchdog: cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall bursts, free stretches, and one long hold-off on request
  initial begin : receiver
    int n;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_pending) begin
        out_stall = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
        hold_pending = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end else begin
        out_stall = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  end

  // Offer one item at a falling edge and hold it until accepted
  task automatic send_item(input logic [7:0] ch, input logic eoe);
    if (gaps_on && sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item  = '{in_char: ch, end_of_expr: eoe};
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Send the built expression, closing it on its last character
  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++) begin
      send_item(expr_q[i], i == expr_q.size() - 1);
      item_cnt++;
    end
  endtask

  task automatic text_to_expr(input string s);
    expr_q.delete();
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'(CH_DIG_LO + $urandom_range(0, 9));
      1:       return 8'(CH_UC_LO + $urandom_range(0, 25));
      default: return 8'(CH_LC_LO + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Well-formed infix expression with random nesting and the odd space
  task automatic build_expr(input int terms);
    int depth;
    expr_q.delete();
    depth = 0;
    for (int t = 0; t < terms; t++) begin
      if (t > 0) expr_q.push_back(rand_operator());
      while (depth < 7 && $urandom_range(0, 3) == 0) begin
        expr_q.push_back(CH_LPAREN);
        depth++;
      end
      expr_q.push_back(rand_operand());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        expr_q.push_back(CH_RPAREN);
        depth--;
      end
      if ($urandom_range(0, 15) == 0) expr_q.push_back(CH_SPACE);
    end
    while (depth > 0) begin
      expr_q.push_back(CH_RPAREN);
      depth--;
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int         n;
    int         pick;
    bit         pressure_done;
    logic [7:0] ch;
    pressure_done = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: priorities, parentheses, unmatched both ways, ignored bytes
    text_to_expr("a+Z*c");
    send_expr();
    text_to_expr("(x-y)/z");
    send_expr();
    text_to_expr("A*9/z-0");
    send_expr();
    text_to_expr(")");
    send_expr();
    text_to_expr("(");
    send_expr();
    send_item(8'h00, 1'b0);
    item_cnt++;
    send_item(8'hFF, 1'b0);
    item_cnt++;
    send_item(CH_SPACE, 1'b1);
    item_cnt++;

    // random: mostly well-formed expressions, some overflow, broken runs and noise
    while (item_cnt < ITEM_TARGET) begin
      if (item_cnt >= CALM_FROM) gaps_on = 1'b0;
      sender_gaps = ($urandom_range(0, 2) != 0);
      if (!pressure_done && item_cnt >= PRESSURE_AT) begin
        // receiver holds off while a long expression keeps coming
        pressure_done = 1'b1;
        hold_pending  = 1'b1;
        build_expr(12);
        send_expr();
      end
      pick = $urandom_range(0, 19);
      if (pick <= 11) begin
        build_expr($urandom_range(1, 8));
        send_expr();
      end else if (pick == 12) begin
        // deep nesting that can run past the stack
        expr_q.delete();
        n = $urandom_range(14, 19);
        for (int k = 0; k < n; k++)
          expr_q.push_back(($urandom_range(0, 4) == 0) ? CH_PLUS : CH_LPAREN);
        expr_q.push_back(rand_operand());
        send_expr();
      end else if (pick <= 16) begin
        // broken run: random tokens, ends anywhere
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(0, 5))
            0:       ch = CH_LPAREN;
            1:       ch = CH_RPAREN;
            2, 3:    ch = rand_operator();
            default: ch = rand_operand();
          endcase
          send_item(ch, $urandom_range(0, 2) == 0);
          item_cnt++;
        end
      end else begin
        // raw byte, mostly ignored by the block
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        item_cnt++;
      end
    end
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
